// ===== rtl/rai_pkg.sv =====
// Shared types, opcodes and defaults for the register ALU instruction executor.
package rai_pkg;

  localparam int NUM_REGS_DEF   = 4;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int MODE_W   = 4;
  localparam int IDX_W    = 2;
  localparam int IMM_W    = 32;
  localparam int OUT_W    = 32;
  localparam int ALU_OP_W = 3;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [IDX_W-1:0]    reg_idx_t;
  typedef logic [ALU_OP_W-1:0] alu_op_t;

  localparam mode_t OP_IN   = MODE_W'(0);
  localparam mode_t OP_MOV  = MODE_W'(1);
  localparam mode_t OP_OUT  = MODE_W'(2);
  localparam mode_t OP_XCHG = MODE_W'(3);
  localparam mode_t OP_ADD  = MODE_W'(4);
  localparam mode_t OP_SUB  = MODE_W'(5);
  localparam mode_t OP_MUL  = MODE_W'(6);
  localparam mode_t OP_DIV  = MODE_W'(7);
  localparam mode_t OP_MOD  = MODE_W'(8);
  localparam mode_t OP_AND  = MODE_W'(9);
  localparam mode_t OP_OR   = MODE_W'(10);
  localparam mode_t OP_XOR  = MODE_W'(11);

  localparam alu_op_t ALU_ADD = ALU_OP_W'(0);
  localparam alu_op_t ALU_SUB = ALU_OP_W'(1);
  localparam alu_op_t ALU_AND = ALU_OP_W'(2);
  localparam alu_op_t ALU_OR  = ALU_OP_W'(3);
  localparam alu_op_t ALU_XOR = ALU_OP_W'(4);

endpackage

// ===== rtl/rai_in_if.sv =====
// Instruction channel: valid/ready handshake with the decoded instruction fields.
interface rai_in_if import rai_pkg::*; ();
  logic                    valid;
  logic                    ready;
  mode_t                   mode;
  reg_idx_t                dest_reg;
  reg_idx_t                src_a_reg;
  reg_idx_t                src_b_reg;
  logic                    three_operand;
  logic signed [IMM_W-1:0] immediate;

  modport source (
    output valid, mode, dest_reg, src_a_reg, src_b_reg, three_operand, immediate,
    input  ready
  );

  modport sink (
    input  valid, mode, dest_reg, src_a_reg, src_b_reg, three_operand, immediate,
    output ready
  );
endinterface

// ===== rtl/rai_out_if.sv =====
// Result channel: valid/ready handshake with the reported value and error flag.
interface rai_out_if import rai_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_value;
  logic                    error;

  modport source (
    output valid, out_valid, out_value, error,
    input  ready
  );

  modport sink (
    input  valid, out_valid, out_value, error,
    output ready
  );
endinterface

// ===== rtl/rai_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/rai_alu.sv =====
// Shared add, subtract and bitwise logic unit used by the execute, multiply, negate, divide and sign-fix steps.
module rai_alu import rai_pkg::*; #(
  parameter int W = 33
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] y
);

  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      ALU_AND: y = a & b;
      ALU_OR:  y = a | b;
      ALU_XOR: y = a ^ b;
      default: y = '0;
    endcase
  end

endmodule

// ===== rtl/register_alu_instruction_executor.sv =====
// Top level: sequencer, operand registers and register file of the instruction executor.
//
//  channel  | dir | transfer when        | payload
//  ---------+-----+----------------------+---------------------------------------------
//  in_ch    | in  | in_ch.valid & ready  | mode, dest_reg, src_a_reg, src_b_reg,
//           |     |                      | three_operand, immediate
//  out_ch   | out | out_ch.valid & ready | out_valid, out_value, error
//
//  IN writes its immediate without a register read; MOV and OUT read one register, the ALU
//  ops and XCHG read two; XCHG writes both, and a zero divisor ends before the divide loop.
//  MUL and DIV/MOD run one bit a cycle through the single shared add/subtract unit,
//  and the register file's single read port takes one operand at a time.
//  Reset: valid bits clear at once, so every register reads as zero; no clearing pass.
//  A new instruction is taken while the previous result waits in the output register;
//  a finished instruction holds in place until that register frees.
module register_alu_instruction_executor import rai_pkg::*; #(
  parameter int NUM_REGS   = NUM_REGS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rai_in_if.sink     in_ch,
  rai_out_if.source  out_ch
);

  localparam int AW    = $clog2(NUM_REGS);
  localparam int DW    = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDX  = 4'd1;
  localparam logic [3:0] S_RDY  = 4'd2;
  localparam logic [3:0] S_EXEC = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_NEGX = 4'd5;
  localparam logic [3:0] S_NEGY = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIX  = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;
  localparam logic [3:0] S_WR2  = 4'd10;
  localparam logic [3:0] S_RESP = 4'd11;

  function automatic logic [AW-1:0] idx_addr(input reg_idx_t idx);
    logic [IDX_W+AW-1:0] e;
    e = {{AW{1'b0}}, idx};
    return e[AW-1:0];
  endfunction

  function automatic logic idx_ok(input reg_idx_t idx);
    logic [IDX_W+AW-1:0] e;
    e = {{AW{1'b0}}, idx};
    return e < (IDX_W+AW)'(NUM_REGS);
  endfunction

  logic [3:0]          state_r, state_nxt;
  logic [NUM_REGS-1:0] vld_r, vld_nxt;
  logic                out_full_r, out_full_nxt;

  mode_t               mode_r, mode_nxt;
  reg_idx_t            d_r, d_nxt;
  reg_idx_t            a_r, a_nxt;
  reg_idx_t            b_r, b_nxt;
  logic                three_r, three_nxt;
  logic [DW-1:0]       x_r, x_nxt;
  logic [DW-1:0]       y_r, y_nxt;
  logic [DW-1:0]       res_r, res_nxt;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic                nx_r, nx_nxt;
  logic                ny_r, ny_nxt;
  logic                err_r, err_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]    out_val_r, out_val_nxt;
  logic                out_err_r, out_err_nxt;

  reg_idx_t            rd_idx;
  reg_idx_t            wr_idx;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [DW-1:0]       wr_data;
  logic                wr_state;
  logic                we;
  logic [DW-1:0]       ram_q;
  logic [DW-1:0]       rd_data;
  logic                load_out;
  logic                out_free;
  logic                arith_in;
  logic                arith_r;
  logic [DW+IMM_W-1:0] imm_ext;
  logic [DW+OUT_W-1:0] x_ext;
  logic [DW-1:0]       fix_sel;
  logic                fix_neg;

  alu_op_t             alu_op;
  logic [DW:0]         alu_a;
  logic [DW:0]         alu_b;
  logic [DW:0]         alu_y;

  rai_alu #(
    .W (DW + 1)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  rai_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_REGS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_full_r;
  assign out_ch.out_valid = out_vld_r;
  assign out_ch.out_value = out_val_r;
  assign out_ch.error     = out_err_r;

  assign out_free = !out_full_r || out_ch.ready;
  assign arith_in = in_ch.mode inside {[OP_ADD:OP_XOR]};
  assign arith_r  = mode_r inside {[OP_ADD:OP_XOR]};
  assign imm_ext  = {{DW{in_ch.immediate[IMM_W-1]}}, in_ch.immediate};
  assign x_ext    = {{OUT_W{x_r[DW-1]}}, x_r};
  assign rd_data  = rd_ok_r ? ram_q : '0;
  assign rd_addr  = idx_addr(rd_idx);
  assign wr_addr  = idx_addr(wr_idx);
  assign we       = wr_state && idx_ok(wr_idx);
  assign fix_sel  = (mode_r == OP_DIV) ? x_r : rem_r;
  assign fix_neg  = (mode_r == OP_DIV) ? (nx_r ^ ny_r) : nx_r;

  always_comb begin
    rd_ok_nxt = idx_ok(rd_idx) ? vld_r[rd_addr] : 1'b0;
    vld_nxt   = vld_r;
    if (we) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    d_nxt       = d_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    three_nxt   = three_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    res_nxt     = res_r;
    rem_nxt     = rem_r;
    nx_nxt      = nx_r;
    ny_nxt      = ny_r;
    err_nxt     = err_r;
    cnt_nxt     = cnt_r;
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    rd_idx      = d_r;
    wr_idx      = d_r;
    wr_data     = res_r;
    wr_state    = 1'b0;
    load_out    = 1'b0;

    case (state_r)
      S_IDLE: begin
        rd_idx = (in_ch.mode == OP_MOV || (arith_in && in_ch.three_operand)) ?
                 in_ch.src_a_reg : in_ch.dest_reg;
        if (in_ch.valid) begin
          mode_nxt  = in_ch.mode;
          d_nxt     = in_ch.dest_reg;
          a_nxt     = in_ch.src_a_reg;
          b_nxt     = in_ch.src_b_reg;
          three_nxt = in_ch.three_operand;
          err_nxt   = 1'b0;
          case (in_ch.mode)
            OP_IN: begin
              res_nxt   = imm_ext[DW-1:0];
              state_nxt = S_WR;
            end
            OP_MOV, OP_OUT, OP_XCHG, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_AND, OP_OR, OP_XOR: begin
              state_nxt = S_RDX;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_RDX: begin
        rd_idx = (mode_r == OP_XCHG || !three_r) ? a_r : b_r;
        x_nxt  = rd_data;
        nx_nxt = rd_data[DW-1];
        case (mode_r)
          OP_MOV: begin
            res_nxt   = rd_data;
            state_nxt = S_WR;
          end
          OP_OUT: begin
            state_nxt = S_RESP;
          end
          default: begin
            state_nxt = arith_r || mode_r == OP_XCHG ? S_RDY : S_RESP;
          end
        endcase
      end
      S_RDY: begin
        y_nxt  = rd_data;
        ny_nxt = rd_data[DW-1];
        case (mode_r)
          OP_XCHG: begin
            res_nxt   = rd_data;
            state_nxt = S_WR;
          end
          OP_MUL: begin
            res_nxt   = '0;
            cnt_nxt   = CNT_W'(DATA_WIDTH - 1);
            state_nxt = S_MUL;
          end
          OP_DIV, OP_MOD: begin
            if (rd_data == '0) begin
              err_nxt   = 1'b1;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_NEGX;
            end
          end
          default: begin
            state_nxt = S_EXEC;
          end
        endcase
      end
      S_EXEC: begin
        case (mode_r)
          OP_SUB:  alu_op = ALU_SUB;
          OP_AND:  alu_op = ALU_AND;
          OP_OR:   alu_op = ALU_OR;
          OP_XOR:  alu_op = ALU_XOR;
          default: alu_op = ALU_ADD;
        endcase
        alu_a     = {1'b0, x_r};
        alu_b     = {1'b0, y_r};
        res_nxt   = alu_y[DW-1:0];
        state_nxt = S_WR;
      end
      S_MUL: begin
        alu_op  = ALU_ADD;
        alu_a   = {1'b0, res_r};
        alu_b   = x_r[0] ? {1'b0, y_r} : '0;
        res_nxt = alu_y[DW-1:0];
        x_nxt   = x_r >> 1;
        y_nxt   = y_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_WR;
        end
      end
      S_NEGX: begin
        alu_op = ALU_SUB;
        alu_b  = {1'b0, x_r};
        if (nx_r) begin
          x_nxt = alu_y[DW-1:0];
        end
        state_nxt = S_NEGY;
      end
      S_NEGY: begin
        alu_op = ALU_SUB;
        alu_b  = {1'b0, y_r};
        if (ny_r) begin
          y_nxt = alu_y[DW-1:0];
        end
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(DATA_WIDTH - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = {rem_r, x_r[DW-1]};
        alu_b  = {1'b0, y_r};
        if (!alu_y[DW]) begin
          rem_nxt = alu_y[DW-1:0];
        end else begin
          rem_nxt = {rem_r[DW-2:0], x_r[DW-1]};
        end
        x_nxt   = {x_r[DW-2:0], !alu_y[DW]};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        alu_op    = ALU_SUB;
        alu_b     = {1'b0, fix_sel};
        res_nxt   = fix_neg ? alu_y[DW-1:0] : fix_sel;
        state_nxt = S_WR;
      end
      S_WR: begin
        wr_state = 1'b1;
        wr_idx   = d_r;
        wr_data  = res_r;
        if (mode_r == OP_XCHG) begin
          state_nxt = S_WR2;
        end else if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_WR2: begin
        wr_state = 1'b1;
        wr_idx   = a_r;
        wr_data  = x_r;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_full_nxt = load_out || (out_full_r && !out_ch.ready);
    out_vld_nxt  = out_vld_r;
    out_val_nxt  = out_val_r;
    out_err_nxt  = out_err_r;
    if (load_out) begin
      out_vld_nxt = (mode_r == OP_OUT);
      out_val_nxt = (mode_r == OP_OUT) ? x_ext[OUT_W-1:0] : '0;
      out_err_nxt = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      vld_r      <= '0;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      vld_r      <= vld_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    d_r       <= d_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    three_r   <= three_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    res_r     <= res_nxt;
    rem_r     <= rem_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    err_r     <= err_nxt;
    cnt_r     <= cnt_nxt;
    rd_ok_r   <= rd_ok_nxt;
    out_vld_r <= out_vld_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

`ifndef ASSERT_OFF
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("executor still ready after taking an instruction");

  a_err_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && err_r |-> mode_r == OP_DIV || mode_r == OP_MOD)
    else $error("error flag raised outside divide or modulo");

  a_out_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.out_valid && out_ch.error))
    else $error("result reports a value and an error together");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.out_valid |-> out_ch.out_value == '0)
    else $error("nonzero value on a result without a report");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == '0 |=> state_r == S_FIX)
    else $error("divide loop did not hand over to sign fix");
`endif

endmodule

// ===== tb/sv/register_alu_instruction_executor_tb.sv =====
// Self-checking testbench for the register ALU instruction executor: directed and random programs.
module register_alu_instruction_executor_tb import rai_pkg::*; ();

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES   = DATA_WIDTH_DEF + 20;

  localparam reg_idx_t REG_AX = IDX_W'(0);
  localparam reg_idx_t REG_BX = IDX_W'(1);
  localparam reg_idx_t REG_CX = IDX_W'(2);
  localparam reg_idx_t REG_DX = IDX_W'(3);

  localparam mode_t FIRST_UNUSED_OP = OP_XOR + MODE_W'(1);
  localparam mode_t LAST_UNUSED_OP  = '1;

  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_1  = 32'hFFFF_FFFF;

  typedef struct packed {
    mode_t       mode;
    reg_idx_t    dest;
    reg_idx_t    src_a;
    reg_idx_t    src_b;
    logic        three;
    logic [31:0] imm;
  } instr_t;

  typedef struct packed {
    logic        reported;
    logic [31:0] value;
    logic        div_fault;
  } result_t;

  logic clk;
  logic rst_n;

  rai_in_if  in_ch ();
  rai_out_if out_ch ();

  register_alu_instruction_executor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [31:0] arch_regs [NUM_REGS_DEF];
  result_t     pending_results [$];

  int src_idle_pct;
  int snk_idle_pct;
  int err_count;
  int n_issued;
  int n_checked;
  int n_faults;
  int n_reports;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  function automatic result_t run_instruction(instr_t ins);
    result_t     res;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] r;
    logic [31:0] ux;
    logic [31:0] uy;
    logic        fault;
    res   = '0;
    r     = '0;
    fault = 1'b0;
    case (ins.mode)
      OP_IN:  arch_regs[ins.dest] = ins.imm;
      OP_MOV: arch_regs[ins.dest] = arch_regs[ins.src_a];
      OP_OUT: begin
        res.reported = 1'b1;
        res.value    = arch_regs[ins.dest];
      end
      OP_XCHG: begin
        x = arch_regs[ins.dest];
        arch_regs[ins.dest]  = arch_regs[ins.src_a];
        arch_regs[ins.src_a] = x;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR: begin
        x = ins.three ? arch_regs[ins.src_a] : arch_regs[ins.dest];
        y = ins.three ? arch_regs[ins.src_b] : arch_regs[ins.src_a];
        case (ins.mode)
          OP_ADD: r = x + y;
          OP_SUB: r = x - y;
          OP_MUL: r = x * y;
          OP_AND: r = x & y;
          OP_OR:  r = x | y;
          OP_XOR: r = x ^ y;
          default: begin
            ux = x[31] ? -x : x;
            uy = y[31] ? -y : y;
            if (uy == '0) begin
              fault = 1'b1;
            end else if (ins.mode == OP_DIV) begin
              r = ux / uy;
              if (x[31] ^ y[31]) r = -r;
            end else begin
              r = ux % uy;
              if (x[31]) r = -r;
            end
          end
        endcase
        if (!fault) arch_regs[ins.dest] = r;
        res.div_fault = fault;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic issue(mode_t op, reg_idx_t d, reg_idx_t a, reg_idx_t b, logic three,
                       logic [31:0] imm);
    instr_t ins;
    ins = '{mode: op, dest: d, src_a: a, src_b: b, three: three, imm: imm};
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= ins.mode;
    in_ch.dest_reg      <= ins.dest;
    in_ch.src_a_reg     <= ins.src_a;
    in_ch.src_b_reg     <= ins.src_b;
    in_ch.three_operand <= ins.three;
    in_ch.immediate     <= ins.imm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(run_instruction(ins));
    n_issued++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: out_valid %0b out_value %0d error %0b",
                 out_ch.out_valid, out_ch.out_value, out_ch.error);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (want.div_fault) n_faults++;
          if (want.reported) n_reports++;
          if (out_ch.out_valid !== want.reported) begin
            $error("out_valid mismatch: expected %0b, got %0b", want.reported,
                   out_ch.out_valid);
            err_count++;
          end
          if (out_ch.out_value !== want.value) begin
            $error("out_value mismatch: expected %0d, got %0d", $signed(want.value),
                   out_ch.out_value);
            err_count++;
          end
          if (out_ch.error !== want.div_fault) begin
            $error("error mismatch: expected %0b, got %0b", want.div_fault, out_ch.error);
            err_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic test_load_and_report();
    issue(OP_IN, REG_AX, REG_BX, REG_CX, 1'b1, MOST_POS);
    issue(OP_IN, REG_BX, REG_AX, REG_AX, 1'b0, MOST_NEG);
    issue(OP_OUT, REG_AX, REG_DX, REG_DX, 1'b1, MINUS_1);
    issue(OP_OUT, REG_BX, REG_CX, REG_AX, 1'b0, '0);
  endtask

  task automatic test_wrapping_arithmetic();
    issue(OP_ADD, REG_CX, REG_AX, REG_BX, 1'b1, '0);
    issue(OP_SUB, REG_AX, REG_BX, REG_DX, 1'b0, '0);
    issue(OP_MUL, REG_DX, REG_BX, REG_BX, 1'b1, '0);
    issue(OP_MUL, REG_AX, REG_AX, REG_CX, 1'b0, '0);
  endtask

  task automatic test_divide_corners();
    issue(OP_IN, REG_CX, REG_AX, REG_AX, 1'b0, MINUS_1);
    issue(OP_DIV, REG_DX, REG_BX, REG_CX, 1'b1, '0);
    issue(OP_MOD, REG_DX, REG_BX, REG_CX, 1'b1, '0);
    issue(OP_IN, REG_AX, REG_AX, REG_AX, 1'b0, '0);
    issue(OP_DIV, REG_DX, REG_AX, REG_AX, 1'b0, '0);
    issue(OP_MOD, REG_DX, REG_BX, REG_AX, 1'b1, '0);
    issue(OP_IN, REG_AX, REG_AX, REG_AX, 1'b1, -32'sd7);
    issue(OP_IN, REG_BX, REG_AX, REG_AX, 1'b0, 32'd2);
    issue(OP_DIV, REG_CX, REG_AX, REG_BX, 1'b1, '0);
    issue(OP_MOD, REG_DX, REG_AX, REG_BX, 1'b1, '0);
  endtask

  task automatic test_logic_and_moves();
    issue(OP_AND, REG_CX, REG_DX, REG_AX, 1'b0, '0);
    issue(OP_OR, REG_DX, REG_AX, REG_BX, 1'b1, '0);
    issue(OP_XOR, REG_BX, REG_CX, REG_CX, 1'b1, '0);
    issue(OP_MOV, REG_DX, REG_AX, REG_BX, 1'b1, '0);
    issue(OP_XCHG, REG_AX, REG_DX, REG_CX, 1'b1, '0);
    issue(OP_XCHG, REG_CX, REG_CX, REG_AX, 1'b0, '0);
  endtask

  task automatic test_unused_opcodes();
    issue(FIRST_UNUSED_OP, REG_AX, REG_BX, REG_CX, 1'b1, MINUS_1);
    issue(LAST_UNUSED_OP, REG_DX, REG_DX, REG_DX, 1'b1, MOST_NEG);
    issue(OP_OUT, REG_DX, REG_AX, REG_AX, 1'b0, '0);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'd1;
      2:       return MINUS_1;
      3:       return MOST_NEG;
      4:       return MOST_POS;
      5, 6:    return 32'($urandom_range(32)) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_programs(int count, int src_pct, int snk_pct);
    mode_t op;
    int    pick;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 18)      op = OP_IN;
      else if (pick < 26) op = OP_OUT;
      else if (pick < 30) op = OP_MOV;
      else if (pick < 34) op = OP_XCHG;
      else if (pick < 37) op = FIRST_UNUSED_OP + mode_t'($urandom_range(3));
      else                op = OP_ADD + mode_t'($urandom_range(7));
      issue(op, reg_idx_t'($urandom_range(3)), reg_idx_t'($urandom_range(3)),
            reg_idx_t'($urandom_range(3)), 1'($urandom_range(1)), pick_operand());
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= OP_IN;
    in_ch.dest_reg      <= REG_AX;
    in_ch.src_a_reg     <= REG_AX;
    in_ch.src_b_reg     <= REG_AX;
    in_ch.three_operand <= 1'b0;
    in_ch.immediate     <= '0;
    err_count    = 0;
    n_issued     = 0;
    n_checked    = 0;
    n_faults     = 0;
    n_reports    = 0;
    src_idle_pct = 19;
    snk_idle_pct = 62;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_load_and_report();
    test_wrapping_arithmetic();
    test_divide_corners();
    test_logic_and_moves();
    test_unused_opcodes();
    test_random_programs(617, 19, 62);
    test_random_programs(617, 62, 19);
    test_random_programs(616, 0, 0);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Executed %0d instructions; %0d results checked, %0d OUT reports,", n_issued,
             n_checked, n_reports);
    $display("%0d zero-divisor faults, across three handshake stall profiles.", n_faults);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== register_alu_instruction_executor.f =====
rtl/rai_pkg.sv
rtl/rai_in_if.sv
rtl/rai_out_if.sv
rtl/rai_ram.sv
rtl/rai_alu.sv
rtl/register_alu_instruction_executor.sv
tb/sv/register_alu_instruction_executor_tb.sv
